// File: rtl/urp_pkg.sv
// Shared types, constants and lead-byte classification for the UTF-8 stream repair block.
package urp_pkg;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW    = $clog2(CMD_DEPTH);

	// Input word kind carried on tuser.
	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	// One queued command: rep_cnt replacement characters, then dat_cnt raw bytes.
	typedef struct packed {
		logic [2:0]      rep_cnt;
		logic [2:0]      dat_cnt;
		logic [3:0][7:0] dat;
	} cmd_t;

	// Sequence length from the lead byte; 0 marks a stray continuation or invalid lead.
	function automatic logic [2:0] seq_len(input logic [7:0] c);
		logic [2:0] len;
		begin
			if (c[7] == 1'b0)              len = 3'd1;
			else if (c[7:5] == 3'b110)     len = 3'd2;
			else if (c[7:4] == 4'b1110)    len = 3'd3;
			else if (c[7:3] == 5'b11110)   len = 3'd4;
			else                           len = 3'd0;
			return len;
		end
	endfunction

endpackage

// File: rtl/urp_front.sv
// Front end: accepts input words, tracks the pending sequence and issues emit commands.
module urp_front import urp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output logic       push,
	output cmd_t       cmd
);

	logic [2:0][7:0] pend_q, pend_nxt;
	logic [1:0]      cnt_q, cnt_nxt;
	logic [2:0]      exp_q, exp_nxt;
	logic [2:0]      len;
	logic            cont;

	assign len  = seq_len(data_byte);
	assign cont = (data_byte[7:6] == 2'b10);

	always_comb begin
		pend_nxt = pend_q;
		cnt_nxt  = cnt_q;
		exp_nxt  = exp_q;
		cmd      = '0;
		if (accept) begin
			if (kind_t'(kind) == KIND_END) begin
				cnt_nxt = 2'd0;
				exp_nxt = 3'd0;
			end else if (cnt_q != 2'd0 && cont) begin
				if ({1'b0, cnt_q} + 3'd1 >= exp_q) begin
					cmd.dat[2:0]    = pend_q;
					cmd.dat[cnt_q]  = data_byte;
					cmd.dat_cnt     = {1'b0, cnt_q} + 3'd1;
					cnt_nxt         = 2'd0;
					exp_nxt         = 3'd0;
				end else begin
					pend_nxt[cnt_q] = data_byte;
					cnt_nxt         = cnt_q + 2'd1;
				end
			end else begin
				// held bytes (if any) become replacements, then judge the byte fresh
				cmd.rep_cnt = {1'b0, cnt_q};
				cnt_nxt     = 2'd0;
				exp_nxt     = 3'd0;
				if (len == 3'd1) begin
					cmd.dat[0]  = data_byte;
					cmd.dat_cnt = 3'd1;
				end else if (len == 3'd0) begin
					cmd.rep_cnt = {1'b0, cnt_q} + 3'd1;
				end else begin
					pend_nxt[0] = data_byte;
					cnt_nxt     = 2'd1;
					exp_nxt     = len;
				end
			end
		end
	end

	assign push = accept && (cmd.rep_cnt != 3'd0 || cmd.dat_cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			exp_q <= 3'd0;
		end else begin
			cnt_q <= cnt_nxt;
			exp_q <= exp_nxt;
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_nxt;
	end

	a_pending_incomplete: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> (exp_q > {1'b0, cnt_q} && exp_q >= 3'd2))
		else $error("pending sequence already complete or bad length");

	a_idle_no_length: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> exp_q == 3'd0)
		else $error("expected length set with nothing pending");

endmodule

// File: rtl/urp_cmd_fifo.sv
// Short command queue between the front end and the byte emitter.
module urp_cmd_fifo import urp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              mem_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wr_ptr_q;
	logic [CMD_AW-1:0] rd_ptr_q;
	logic [CMD_AW:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == (CMD_AW+1)'(CMD_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (CMD_AW+1)'(CMD_DEPTH))
		else $error("command queue overflow");

	a_no_lost_push: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into full queue");

endmodule

// File: rtl/urp_back.sv
// Back end: expands queued commands into output bytes through an output register.
module urp_back import urp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	logic [2:0] rep_done_q;
	logic [1:0] sub_q;
	logic [1:0] dat_idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       load;
	logic       in_rep;
	logic [7:0] cur_byte;
	logic       cur_last;
	logic       fire;

	assign load   = !out_valid_q || m_tready;
	assign fire   = load && head_valid;
	assign in_rep = (rep_done_q < head_cmd.rep_cnt);

	always_comb begin
		cur_byte = head_cmd.dat[dat_idx_q];
		cur_last = ({1'b0, dat_idx_q} + 3'd1 == head_cmd.dat_cnt);
		if (in_rep) begin
			case (sub_q)
				2'd0:    cur_byte = REPL_B0;
				2'd1:    cur_byte = REPL_B1;
				default: cur_byte = REPL_B2;
			endcase
			cur_last = (sub_q == 2'd2) && (rep_done_q + 3'd1 == head_cmd.rep_cnt)
				&& (head_cmd.dat_cnt == 3'd0);
		end
	end

	assign pop = fire && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_done_q  <= 3'd0;
			sub_q       <= 2'd0;
			dat_idx_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				if (cur_last) begin
					rep_done_q <= 3'd0;
					sub_q      <= 2'd0;
					dat_idx_q  <= 2'd0;
				end else if (in_rep) begin
					if (sub_q == 2'd2) begin
						sub_q      <= 2'd0;
						rep_done_q <= rep_done_q + 3'd1;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end else begin
					dat_idx_q <= dat_idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q <= cur_byte;
			out_last_q <= cur_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head_cmd.rep_cnt != 3'd0 || head_cmd.dat_cnt != 3'd0))
		else $error("empty command in queue");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (rep_done_q <= head_cmd.rep_cnt && sub_q != 2'd3))
		else $error("emitter position beyond command");

endmodule

// File: rtl/utf8_stream_repair_top.sv
// Top level of the UTF-8 stream repair filter.
//
// Input channel s_*: one word per raw byte. s_tdata carries data_byte, s_tuser carries
// kind (0 = data byte, 1 = end of stream, which drops any held partial sequence).
// Output channel m_*: one word per output byte; m_tlast marks the final byte caused
// by one input word. Input words that complete nothing produce no output words.
// A multi-byte character is held until whole, then sent byte by byte. A stray or
// invalid byte, and each held byte of an interrupted sequence, becomes EF BF BD.
// The front end takes one word per cycle while the queue is not full and queues one
// command per productive word in a 4-entry queue; the emitter sends one output byte per
// cycle unless m_tready stalls, from an output register; a productive word yields 1 to 12 bytes.
// The first output byte is registered in the command queue, then in the output register.
// s_tready drops only while the command queue is full; a stall on m_tready holds the
// output word and backs up into the queue. Reset clears the held sequence, the queue
// and the output register; no clearing pass is needed.
module utf8_stream_repair_top import urp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] kind
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast
);

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic full;
	logic head_valid;
	cmd_t head_cmd;
	logic pop;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	urp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (s_tuser),
		.data_byte (s_tdata),
		.push      (push),
		.cmd       (push_cmd)
	);

	urp_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	urp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// File: dv/utf8_stream_repair_top_tb.sv
// Self-checking testbench for the UTF-8 stream repair filter: directed and random byte streams.
module utf8_stream_repair_top_tb;
	import urp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
	} in_word_t;

	typedef struct {
		logic [7:0] ob;
		logic       last;
	} out_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tuser = KIND_DATA;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	in_word_t  src_q[$];
	out_word_t repaired_q[$];
	int        total_words;
	int        sent_words;
	int        errors;

	// predictor state: held sequence
	logic [7:0] held[3];
	int         held_cnt;
	int         held_len;

	utf8_stream_repair_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int utf8_len_of(logic [7:0] c);
		casez (c)
			8'b0???????: return 1;
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	task automatic push_out(logic [7:0] b);
		out_word_t o;
		o.ob = b;
		o.last = 1'b0;
		repaired_q = {repaired_q, o};
	endtask

	task automatic push_fffd();
		push_out(REPL_B0);
		push_out(REPL_B1);
		push_out(REPL_B2);
	endtask

	task automatic drop_held();
		held[0] = 8'h00;
		held[1] = 8'h00;
		held[2] = 8'h00;
		held_cnt = 0;
		held_len = 0;
	endtask

	task automatic judge_fresh(logic [7:0] b);
		int len;
		len = utf8_len_of(b);
		if (len == 1) begin
			push_out(b);
		end else if (len == 0) begin
			push_fffd();
		end else begin
			held[0] = b;
			held_cnt = 1;
			held_len = len;
		end
	endtask

	task automatic predict_repair(in_word_t w);
		int first;
		first = repaired_q.size();
		if (w.kind == KIND_END) begin
			drop_held();
		end else if (held_cnt == 0) begin
			judge_fresh(w.data);
		end else if (w.data[7:6] == 2'b10) begin
			if (held_cnt + 1 >= held_len) begin
				for (int k = 0; k < held_cnt; k++)
					push_out(held[k]);
				push_out(w.data);
				drop_held();
			end else begin
				held[held_cnt] = w.data;
				held_cnt++;
			end
		end else begin
			for (int k = 0; k < held_cnt; k++)
				push_fffd();
			drop_held();
			judge_fresh(w.data);
		end
		if (repaired_q.size() > first)
			repaired_q[repaired_q.size() - 1].last = 1'b1;
	endtask

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic add_word(kind_t kind, logic [7:0] data);
		in_word_t w;
		w.kind = kind;
		w.data = data;
		src_q = {src_q, w};
	endtask

	task automatic add_bytes(logic [7:0] b[$]);
		foreach (b[i])
			add_word(KIND_DATA, b[i]);
	endtask

	function automatic logic [7:0] rand_lead(int len);
		case (len)
			2:       return 8'($urandom_range(8'hDF, 8'hC0));
			3:       return 8'($urandom_range(8'hEF, 8'hE0));
			4:       return 8'($urandom_range(8'hF7, 8'hF0));
			default: return 8'($urandom_range(8'h7F, 8'h00));
		endcase
	endfunction

	function automatic logic [7:0] rand_cont();
		return 8'($urandom_range(8'hBF, 8'h80));
	endfunction

	// idle percentages by phase: receiver first slow, then sender, then neither
	function automatic int phase_of();
		if (total_words == 0)
			return 0;
		return (sent_words * 3) / total_words;
	endfunction

	function automatic int send_idle_pct();
		case (phase_of())
			0:       return 27;
			1:       return 61;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (phase_of())
			0:       return 61;
			1:       return 27;
			default: return 0;
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_repair(src_q[0]);
				void'(src_q.pop_front());
				sent_words++;
			end
			if (s_tvalid && !s_tready) begin
				// hold word until taken
			end else if (src_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
				s_tvalid <= 1'b1;
				s_tuser  <= src_q[0].kind;
				s_tdata  <= src_q[0].data;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (repaired_q.size() == 0) begin
					report_mismatch("unexpected word", m_tdata, 8'h00);
				end else begin
					if (m_tdata !== repaired_q[0].ob)
						report_mismatch("out_byte", m_tdata, repaired_q[0].ob);
					if (m_tlast !== repaired_q[0].last)
						report_mismatch("last", {7'b0, m_tlast}, {7'b0, repaired_q[0].last});
					void'(repaired_q.pop_front());
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct());
		end
	end

	initial begin
		int len;
		int n;
		errors = 0;
		sent_words = 0;
		total_words = 0;
		drop_held();

		// ASCII extremes, whole 2/3/4-byte chars (F5 lead accepted)
		add_bytes('{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC});
		add_bytes('{8'hF5, 8'hBF, 8'hBF, 8'hBF});
		// stray continuation and invalid leads
		add_bytes('{8'h80, 8'hFF, 8'hF8});
		// interrupted by ASCII, then by an invalid byte (twelve-byte burst)
		add_bytes('{8'hE2, 8'h82, 8'h41});
		add_bytes('{8'hF0, 8'h90, 8'h80, 8'hFF});
		// end of stream drops a held lead; data ignored on end
		add_word(KIND_DATA, 8'hC3);
		add_word(KIND_END, 8'hFF);
		add_word(KIND_END, 8'h00);
		add_word(KIND_DATA, 8'h41);

		while (src_q.size() < 350) begin
			n = $urandom_range(99);
			if (n < 55) begin
				len = $urandom_range(4, 1);
				add_word(KIND_DATA, rand_lead(len));
				for (int k = 1; k < len; k++)
					add_word(KIND_DATA, rand_cont());
			end else if (n < 70) begin
				len = $urandom_range(4, 2);
				add_word(KIND_DATA, rand_lead(len));
				repeat ($urandom_range(len - 2, 0))
					add_word(KIND_DATA, rand_cont());
			end else if (n < 90) begin
				add_word(KIND_DATA, 8'($urandom_range(255, 0)));
			end else if (n < 95) begin
				repeat ($urandom_range(3, 1))
					add_word(KIND_DATA, rand_cont());
			end else begin
				add_word(KIND_END, 8'($urandom_range(255, 0)));
			end
		end
		total_words = src_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (src_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (repaired_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("utf8_stream_repair_top_tb passed");
		else
			$display("utf8_stream_repair_top_tb failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("utf8_stream_repair_top_tb failed");
		$finish;
	end

endmodule
